### rtl/core/lock_wait_blame_table_top_defines.svh
// ----------------------------------------------------------------------------
// Lock wait blame table assertion macros
// Shared concurrent check wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOCK_WAIT_BLAME_TABLE_TOP_DEFINES_SVH
`define LOCK_WAIT_BLAME_TABLE_TOP_DEFINES_SVH

// Same-cycle implication
`define LWBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwbt: same-cycle check failed");

// Next-cycle implication
`define LWBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwbt: next-cycle check failed");

`endif

### rtl/core/lwbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock wait blame table package
// Field widths, outcome codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package lwbt_pkg;

    localparam int ADDR_W   = 48;
    localparam int WORD_W   = ADDR_W - 2;
    localparam int ID_W     = 32;
    localparam int CNT_W    = 32;
    localparam int ENTRY_W  = ID_W + CNT_W;
    localparam int PERIOD_W = 31;
    localparam int BLAME_W  = 63;
    localparam int OUTC_W   = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_IGNORED  = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_COUNTED  = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_CLAIMED  = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_COLLIDE  = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_RELEASED = 3'd4;
    localparam logic [OUTC_W-1:0] OUT_MISS     = 3'd5;

    // Classified event handed to the table side
    typedef struct packed {
        logic            op;      // 1 = release
        logic            ignore;  // zero id or uncounted sample
        logic [ID_W-1:0] id;
    } cmd_t;

endpackage

### rtl/core/lock_wait_blame_table_top.sv
`timescale 1ns / 1ps
// Lock wait blame table: a direct-mapped table of per-lock wait sample counts,
// indexed by the lock address above bit 1 modulo TABLE_DEPTH. After reset the
// block clears every table entry and holds s_axis_tready low meanwhile;
// configuration writes are taken at any time. Each event then passes through
// the table side as a registered read of the entry, then compare, write-back
// and period multiply, and its result beat is registered once the output
// register is free. With a power-of-two depth the front end pushes the command
// in the accept cycle; otherwise it reduces the word address modulo the depth
// one byte at a time, then queues the command.
// ----------------------------------------------------------------------------
// Lock wait blame table top level
// Front end, command queue, table side and the sampling period register.
// ----------------------------------------------------------------------------
module lock_wait_blame_table_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lwbt_pkg::PERIOD_W-1:0] cfg_data,      // sample_period
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lwbt_pkg::ADDR_W-1:0]   s_axis_tdata,  // [47:0] lock_address
    input  logic [1:0]                    s_axis_tuser,  // [0] operation, [1] sample_counts
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // [62:0] blame_value
    output logic [3:0]                    m_axis_tuser   // [2:0] outcome, [3] report_valid
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CMD_W = $bits(lwbt_pkg::cmd_t);
    localparam int Q_W   = CMD_W + IDX_W;

    logic [lwbt_pkg::PERIOD_W-1:0] period_reg;
    logic                          clearing;
    logic                          push;
    logic                          pop;
    logic                          q_full;
    logic                          q_empty;
    lwbt_pkg::cmd_t                f_cmd;
    logic [IDX_W-1:0]              f_idx;
    logic [Q_W-1:0]                q_rdata;
    lwbt_pkg::cmd_t                q_cmd;
    logic [IDX_W-1:0]              q_idx;

    // Sampling period register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= cfg_data;
        end
    end

    lwbt_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .clearing      (clearing),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fifo_full     (q_full),
        .push          (push),
        .cmd           (f_cmd),
        .idx           (f_idx)
    );

    lwbt_fifo #(
        .W (Q_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_cmd, f_idx}),
        .full  (q_full),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Split the queued beat into command and index
    assign q_cmd = lwbt_pkg::cmd_t'(q_rdata[Q_W-1:IDX_W]);
    assign q_idx = q_rdata[IDX_W-1:0];

    lwbt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .period        (period_reg),
        .fifo_empty    (q_empty),
        .cmd           (q_cmd),
        .idx           (q_idx),
        .pop           (pop),
        .clearing      (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### rtl/core/lwbt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock wait blame table front end
// Takes event beats, derives lock id and table index, flags ignored events.
// ----------------------------------------------------------------------------
module lwbt_front #(
    parameter int TABLE_DEPTH = 4096,
    parameter int IDX_W       = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clearing,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lwbt_pkg::ADDR_W-1:0] s_axis_tdata,   // [47:0] lock_address
    input  logic [1:0]                  s_axis_tuser,   // [0] operation, [1] sample_counts
    input  logic                        fifo_full,
    output logic                        push,
    output lwbt_pkg::cmd_t              cmd,
    output logic [IDX_W-1:0]            idx
);

    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

    logic [lwbt_pkg::WORD_W-1:0] in_word;
    logic [lwbt_pkg::ID_W-1:0]   in_id;

    assign in_word = s_axis_tdata[lwbt_pkg::ADDR_W-1:2];
    assign in_id   = in_word[lwbt_pkg::ID_W-1:0];

    if (IS_POW2) begin : g_pow2
        // Index is the low word bits: classify and push in the accept cycle
        assign s_axis_tready = !clearing && !fifo_full;
        assign push          = s_axis_tvalid && s_axis_tready;
        assign idx           = in_word[IDX_W-1:0];
        assign cmd.op        = s_axis_tuser[0];
        assign cmd.ignore    = (in_id == '0) || (!s_axis_tuser[0] && !s_axis_tuser[1]);
        assign cmd.id        = in_id;
    end else begin : g_rem
        // Index is word modulo depth: restoring remainder, one byte per cycle
        localparam int NSTEP  = (lwbt_pkg::WORD_W + 7) / 8;
        localparam int PAD_W  = NSTEP * 8;
        localparam int STEP_W = $clog2(NSTEP + 1);
        localparam logic [IDX_W:0]    DEPTH_V   = (IDX_W + 1)'(TABLE_DEPTH);
        localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP);

        logic                      busy_reg, busy_next;
        logic [STEP_W-1:0]         step_reg, step_next;
        logic [PAD_W-1:0]          word_reg;
        logic [IDX_W-1:0]          rem_reg;
        logic [lwbt_pkg::ID_W-1:0] id_reg;
        logic                      op_reg;
        logic                      counts_reg;
        logic [IDX_W:0]            rem_acc;
        logic [7:0]                chunk;
        logic                      accept;
        logic                      working;

        assign s_axis_tready = !clearing && !busy_reg;
        assign accept        = s_axis_tvalid && s_axis_tready;
        assign working       = busy_reg && (step_reg != LAST_STEP);
        assign push          = busy_reg && (step_reg == LAST_STEP) && !fifo_full;
        assign chunk         = word_reg[PAD_W-1 -: 8];

        // Eight restoring steps on the current top byte
        always_comb
        begin
            rem_acc = {1'b0, rem_reg};
            for (int i = 0; i < 8; i++)
            begin
                rem_acc = {rem_acc[IDX_W-1:0], chunk[7-i]};
                if (rem_acc >= DEPTH_V)
                begin
                    rem_acc = rem_acc - DEPTH_V;
                end
            end
        end

        always_comb
        begin
            busy_next = busy_reg;
            step_next = step_reg;
            if (accept)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
            else if (working)
            begin
                step_next = step_reg + 1'b1;
            end
            else if (push)
            begin
                busy_next = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg <= 1'b0;
                step_reg <= '0;
            end
            else
            begin
                busy_reg <= busy_next;
                step_reg <= step_next;
            end
        end

        // Item payload and running remainder
        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                word_reg   <= PAD_W'(in_word);
                rem_reg    <= '0;
                id_reg     <= in_id;
                op_reg     <= s_axis_tuser[0];
                counts_reg <= s_axis_tuser[1];
            end
            else if (working)
            begin
                word_reg <= word_reg << 8;
                rem_reg  <= rem_acc[IDX_W-1:0];
            end
        end

        assign idx        = rem_reg;
        assign cmd.op     = op_reg;
        assign cmd.ignore = (id_reg == '0) || (!op_reg && !counts_reg);
        assign cmd.id     = id_reg;
    end

endmodule

### rtl/core/lwbt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock wait blame table command queue
// Two-entry queue between the front end and the table side.
// ----------------------------------------------------------------------------
module lwbt_fifo #(
    parameter int W = 46
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    logic [W-1:0] ent_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = ent_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/lwbt_back.sv
`timescale 1ns / 1ps
`include "lock_wait_blame_table_top_defines.svh"
// ----------------------------------------------------------------------------
// Lock wait blame table back end
// Holds the table, runs the clearing pass and the per-event read-modify-write,
// scales released counts by the period and drives the result beat.
// ----------------------------------------------------------------------------
module lwbt_back #(
    parameter int TABLE_DEPTH = 4096,
    parameter int IDX_W       = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lwbt_pkg::PERIOD_W-1:0] period,
    input  logic                          fifo_empty,
    input  lwbt_pkg::cmd_t                cmd,
    input  logic [IDX_W-1:0]              idx,
    output logic                          pop,
    output logic                          clearing,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // [62:0] blame_value
    output logic [3:0]                    m_axis_tuser   // [2:0] outcome, [3] report_valid
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [lwbt_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];

    logic [1:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              clr_idx_reg, clr_idx_next;
    logic                          out_valid_reg, out_valid_next;
    lwbt_pkg::cmd_t                cmd_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [lwbt_pkg::ENTRY_W-1:0]  rd_entry_reg;
    logic [lwbt_pkg::OUTC_W-1:0]   outc_reg, outc_next;
    logic                          rep_reg, rep_next;
    logic [lwbt_pkg::BLAME_W-1:0]  prod_reg;
    logic [lwbt_pkg::BLAME_W-1:0]  blame_reg;
    logic [lwbt_pkg::OUTC_W-1:0]   out_outc_reg;
    logic                          out_rep_reg;

    logic                          wr_en;
    logic [IDX_W-1:0]              wr_idx;
    logic [lwbt_pkg::ENTRY_W-1:0]  wr_data;
    logic [lwbt_pkg::ID_W-1:0]     held;
    logic [lwbt_pkg::CNT_W-1:0]    count;
    logic [lwbt_pkg::CNT_W-1:0]    count_inc;
    logic                          hit;
    logic                          out_load;
    logic [lwbt_pkg::BLAME_W-1:0]  blame_sel;

    assign clearing = state_reg == ST_CLEAR;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign pop      = ((state_reg == ST_IDLE) || out_load) && !fifo_empty;

    assign held      = rd_entry_reg[lwbt_pkg::ENTRY_W-1:lwbt_pkg::CNT_W];
    assign count     = rd_entry_reg[lwbt_pkg::CNT_W-1:0];
    assign count_inc = (count == lwbt_pkg::COUNT_MAX) ? count : count + 1'b1;
    assign hit       = held == cmd_reg.id;

    // Entry decision and table write
    always_comb
    begin
        wr_en     = 1'b0;
        wr_idx    = idx_reg;
        wr_data   = '0;
        outc_next = lwbt_pkg::OUT_IGNORED;
        rep_next  = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en  = 1'b1;
            wr_idx = clr_idx_reg;
        end
        else if (state_reg == ST_EVAL)
        begin
            priority if (cmd_reg.ignore)
            begin
                outc_next = lwbt_pkg::OUT_IGNORED;
            end
            else if (!cmd_reg.op && hit)
            begin
                outc_next = lwbt_pkg::OUT_COUNTED;
                wr_en     = 1'b1;
                wr_data   = {cmd_reg.id, count_inc};
            end
            else if (!cmd_reg.op && held == '0)
            begin
                outc_next = lwbt_pkg::OUT_CLAIMED;
                wr_en     = 1'b1;
                wr_data   = {cmd_reg.id, lwbt_pkg::CNT_W'(1)};
            end
            else if (!cmd_reg.op)
            begin
                outc_next = lwbt_pkg::OUT_COLLIDE;
            end
            else if (hit)
            begin
                outc_next = lwbt_pkg::OUT_RELEASED;
                rep_next  = count != '0;
                wr_en     = 1'b1;
            end
            else
            begin
                outc_next = lwbt_pkg::OUT_MISS;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = pop ? ST_EVAL : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (pop)
        begin
            rd_entry_reg <= mem[idx];
        end
    end

    // Blame select: scaled count, raw count when period is zero, zero when not a report
    assign blame_sel = !rep_reg         ? '0 :
                       (period != '0)   ? prod_reg :
                       lwbt_pkg::BLAME_W'(count);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd;
            idx_reg <= idx;
        end
        if (state_reg == ST_EVAL)
        begin
            outc_reg <= outc_next;
            rep_reg  <= rep_next;
            prod_reg <= lwbt_pkg::BLAME_W'(count) * lwbt_pkg::BLAME_W'(period);
        end
        if (out_load)
        begin
            blame_reg    <= blame_sel;
            out_outc_reg <= outc_reg;
            out_rep_reg  <= rep_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, blame_reg};
    assign m_axis_tuser  = {out_rep_reg, out_outc_reg};

    // Checks
    `LWBT_ASSERT_IMP(a_no_pop_in_clear, state_reg == ST_CLEAR, !pop)
    `LWBT_ASSERT_IMP(a_ignore_no_write, state_reg == ST_EVAL && cmd_reg.ignore, !wr_en)
    `LWBT_ASSERT_IMP(a_report_is_release, out_valid_reg && out_rep_reg,
                     out_outc_reg == lwbt_pkg::OUT_RELEASED)
    `LWBT_ASSERT_NXT(a_eval_then_out, state_reg == ST_EVAL, state_reg == ST_OUT)

endmodule
